[sv/tmp_pkg.sv]
// Shared types and constants for the temporal mask persistence block.
package tmp_pkg;

    localparam int unsigned WINDOW_DEF       = 8;
    localparam int unsigned FRAME_PIXELS_DEF = 262144;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned THR_W   = 8;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PIX_W-1:0] SET_VALUE    = 8'hFF;
    localparam logic [THR_W-1:0] THRESH_RESET = 8'd4;

    // Register index, taken from paddr[2].
    localparam logic REG_THRESH = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0] mask_pixel;
        logic             frame_end;
    } t_in;

    typedef struct packed {
        logic persistent;
        logic window_full;
        logic frame_end_out;
    } t_out;

    typedef struct packed {
        logic newbit;
        logic frame_end;
        logic full;
    } t_flags;

endpackage

[sv/tmp_mem.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
module tmp_mem #(
    parameter int unsigned DEPTH = tmp_pkg::FRAME_PIXELS_DEF,
    parameter int unsigned WIDTH = 12,
    parameter int unsigned AW    = 18
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/tmp_ctrl.sv]
// Frame sequencing: pixel position, ring plane, frame count and post-reset clear pass.
module tmp_ctrl #(
    parameter  int unsigned WINDOW       = tmp_pkg::WINDOW_DEF,
    parameter  int unsigned FRAME_PIXELS = tmp_pkg::FRAME_PIXELS_DEF,
    localparam int unsigned POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
    localparam int unsigned PLANE_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic                 i_frame_end,
    output logic [POS_W-1:0]     o_pos,
    output logic [PLANE_W-1:0]   o_plane,
    output logic                 o_full,
    output logic                 o_clearing,
    output logic [POS_W-1:0]     o_clr_addr
);

    localparam int unsigned FS_W    = $clog2(WINDOW + 1);

    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [PLANE_W-1:0] r_plane,  n_plane;
    logic [FS_W-1:0]    r_frames, n_frames;
    logic               r_clear,  n_clear;
    logic [POS_W-1:0]   r_clr,    n_clr;
    logic               frame_done;

    assign frame_done = i_frame_end || (r_pos == POS_W'(FRAME_PIXELS - 1));

    always_comb begin
        n_pos    = r_pos;
        n_plane  = r_plane;
        n_frames = r_frames;
        if (i_acc) begin
            if (frame_done) begin
                n_pos   = '0;
                n_plane = (r_plane == PLANE_W'(WINDOW - 1)) ? '0 : r_plane + 1'b1;
                if (r_frames < FS_W'(WINDOW)) begin
                    n_frames = r_frames + 1'b1;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        n_clear = r_clear;
        n_clr   = r_clr;
        if (r_clear) begin
            if (r_clr == POS_W'(FRAME_PIXELS - 1)) begin
                n_clear = 1'b0;
            end else begin
                n_clr = r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_plane  <= '0;
            r_frames <= '0;
            r_clear  <= 1'b1;
            r_clr    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_plane  <= n_plane;
            r_frames <= n_frames;
            r_clear  <= n_clear;
            r_clr    <= n_clr;
        end
    end

    assign o_pos      = r_pos;
    assign o_plane    = r_plane;
    assign o_full     = (r_frames >= FS_W'(WINDOW - 1));
    assign o_clearing = r_clear;
    assign o_clr_addr = r_clr;

endmodule

[sv/tmp_rmw.sv]
// Read-modify-write stage: history/count update, forwarding and output register.
module tmp_rmw #(
    parameter  int unsigned WINDOW       = tmp_pkg::WINDOW_DEF,
    parameter  int unsigned FRAME_PIXELS = tmp_pkg::FRAME_PIXELS_DEF,
    localparam int unsigned POS_W        = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1,
    localparam int unsigned PLANE_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int unsigned CNT_W        = $clog2(WINDOW + 1),
    localparam int unsigned ENT_W        = WINDOW + CNT_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  logic [POS_W-1:0]          i_pos,
    input  logic [PLANE_W-1:0]        i_plane,
    input  tmp_pkg::t_flags           i_flags,
    input  logic [ENT_W-1:0]          i_rdata,
    input  logic [tmp_pkg::THR_W-1:0] i_thresh,
    output logic                      o_s1_ready,
    output logic                      o_we,
    output logic [POS_W-1:0]          o_waddr,
    output logic [ENT_W-1:0]          o_wdata,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output tmp_pkg::t_out             o_out
);

    logic                 r_s1_valid, n_s1_valid;
    logic [POS_W-1:0]     r_s1_pos;
    logic [PLANE_W-1:0]   r_s1_plane;
    tmp_pkg::t_flags      r_s1_flags;
    logic                 r_fwd;
    logic [ENT_W-1:0]     r_fwd_data;
    logic                 r_out_valid, n_out_valid;
    tmp_pkg::t_out        r_out;

    logic                 s1_adv;
    logic [ENT_W-1:0]     entry;
    logic [WINDOW-1:0]    hist, n_hist;
    logic [CNT_W-1:0]     cnt, cnt_dec, cnt_new;
    logic                 oldbit;
    tmp_pkg::t_out        res;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_s1_ready = !r_s1_valid || s1_adv;

    // Entry written on the same edge this one was read is taken from the bypass.
    assign entry  = r_fwd ? r_fwd_data : i_rdata;
    assign hist   = entry[WINDOW-1:0];
    assign cnt    = entry[ENT_W-1:WINDOW];
    assign oldbit = hist[r_s1_plane];

    always_comb begin
        n_hist             = hist;
        n_hist[r_s1_plane] = r_s1_flags.newbit;
        cnt_dec            = (oldbit && (cnt != '0)) ? cnt - 1'b1 : cnt;
        cnt_new            = (r_s1_flags.newbit && (cnt_dec < CNT_W'(WINDOW)))
                             ? cnt_dec + 1'b1 : cnt_dec;
        res.window_full    = r_s1_flags.full;
        res.persistent     = r_s1_flags.full && (8'(cnt_new) >= i_thresh);
        res.frame_end_out  = r_s1_flags.frame_end;
    end

    assign o_we    = s1_adv;
    assign o_waddr = r_s1_pos;
    assign o_wdata = {cnt_new, n_hist};

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (i_acc) begin
                r_fwd <= s1_adv && (i_pos == r_s1_pos);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_pos   <= i_pos;
            r_s1_plane <= i_plane;
            r_s1_flags <= i_flags;
            r_fwd_data <= o_wdata;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> (!r_s1_valid || s1_adv))
        else $error("stage 1 overwritten while holding a transaction");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |-> (cnt_new <= CNT_W'(WINDOW)))
        else $error("set count exceeds window");

    a_pers_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.persistent || r_out.window_full))
        else $error("persistent flagged before window full");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("processed transaction did not reach output register");

endmodule

[sv/temporal_mask_persistence.sv]
// Top level of the temporal mask persistence block: APB register, memory and pipeline.
// Accepts one mask pixel per clock while not clearing or stalled, and returns one result
// per pixel through the update stage and the output register. Each pixel position owns
// one memory word holding its last WINDOW frame bits and their set count; the word is
// read when the pixel is taken and written back from the update stage, with a bypass so
// a position that repeats in the next pixel (one-pixel frames) sees its fresh value.
// After reset a clearing pass writes every word once, during which no pixel is taken;
// the threshold register can be written meanwhile. Output stalls hold the pipeline only
// once both the output register and the update stage are full.
module temporal_mask_persistence #(
    parameter int unsigned WINDOW       = tmp_pkg::WINDOW_DEF,
    parameter int unsigned FRAME_PIXELS = tmp_pkg::FRAME_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tmp_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tmp_pkg::t_out               o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmp_pkg::PADDR_W-1:0] paddr,
    input  logic [tmp_pkg::PDATA_W-1:0] pwdata,
    output logic [tmp_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int unsigned POS_W   = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int unsigned PLANE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
    localparam int unsigned ENT_W   = WINDOW + CNT_W;

    logic [tmp_pkg::THR_W-1:0] r_thresh;
    logic                      cfg_wr;

    logic                 in_acc;
    logic                 s1_ready;
    logic [POS_W-1:0]     pos;
    logic [PLANE_W-1:0]   plane;
    logic                 full;
    logic                 clearing;
    logic [POS_W-1:0]     clr_addr;
    tmp_pkg::t_flags      flags;

    logic                 rmw_we;
    logic [POS_W-1:0]     rmw_waddr;
    logic [ENT_W-1:0]     rmw_wdata;
    logic                 mem_we;
    logic [POS_W-1:0]     mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic [ENT_W-1:0]     mem_rdata;

    // Configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == tmp_pkg::REG_THRESH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= tmp_pkg::THRESH_RESET;
        end else if (cfg_wr) begin
            r_thresh <= pwdata[tmp_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            tmp_pkg::REG_THRESH: prdata = {{(tmp_pkg::PDATA_W - tmp_pkg::THR_W){1'b0}}, r_thresh};
            default:             prdata = '0;
        endcase
    end

    // Datapath
    assign o_in_ready = !clearing && s1_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    assign flags.newbit    = (i_in.mask_pixel == tmp_pkg::SET_VALUE);
    assign flags.frame_end = i_in.frame_end;
    assign flags.full      = full;

    tmp_ctrl #(
        .WINDOW       (WINDOW),
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_frame_end (i_in.frame_end),
        .o_pos       (pos),
        .o_plane     (plane),
        .o_full      (full),
        .o_clearing  (clearing),
        .o_clr_addr  (clr_addr)
    );

    assign mem_we    = clearing || rmw_we;
    assign mem_waddr = clearing ? clr_addr : rmw_waddr;
    assign mem_wdata = clearing ? '0 : rmw_wdata;

    tmp_mem #(
        .DEPTH (FRAME_PIXELS),
        .WIDTH (ENT_W),
        .AW    (POS_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (pos),
        .o_rdata (mem_rdata)
    );

    tmp_rmw #(
        .WINDOW       (WINDOW),
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_pos       (pos),
        .i_plane     (plane),
        .i_flags     (flags),
        .i_rdata     (mem_rdata),
        .i_thresh    (r_thresh),
        .o_s1_ready  (s1_ready),
        .o_we        (rmw_we),
        .o_waddr     (rmw_waddr),
        .o_wdata     (rmw_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
